// File: design/rgb_fade_with_breathing_macros.svh
// assertion macros for the rgb fader with breathing
`ifndef RGB_FADE_WITH_BREATHING_MACROS_SVH
`define RGB_FADE_WITH_BREATHING_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define RFB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent that must hold in the cycle after the antecedent
`define RFB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`else

`define RFB_ASSERT(name, prop, msg)
`define RFB_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: design/rfb_pkg.sv
// shared types, widths, register codes and sine table of the rgb fader
`default_nettype none

package rfb_pkg;

  localparam int FX_W       = 29;   // level and step, signed, 16 fraction bits
  localparam int FRAC_W     = 16;
  localparam int C_W        = FX_W - 1;  // clamped level, always non-negative
  localparam int TGT_W      = 10;
  localparam int DUTY_W     = 10;
  localparam int DEPTH_W    = 8;
  localparam int TICK_W     = 16;
  localparam int PHASE_W    = 10;
  localparam int SINE_W     = 9;
  localparam int LUT_IDX_W  = 6;
  localparam int DS_W       = 16;   // depth * sine, 16 fraction bits
  localparam int ACC_W      = C_W + DS_W;
  localparam int REM_W      = 16;   // divider remainder, holds up to the divisor
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_CH     = 3;
  localparam int CH_W       = 2;
  localparam int DIV_STEPS  = FX_W;  // one quotient bit per cycle
  localparam int MUL_STEPS  = DS_W;  // one multiplier bit per cycle
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_BREATH_DEPTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 8'd1;

  localparam logic [DEPTH_W-1:0] DEPTH_RST   = 8'd169;
  localparam logic [TICK_W-1:0]  TIMEOUT_RST = 16'd1100;
  localparam logic [DUTY_W-1:0]  DUTY_SAT    = '1;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
  localparam fx_t FX_MIN = {1'b1, {(FX_W-1){1'b0}}};

  // quarter wave, round(256 * sin(k * pi / 64)) for k = 0..32
  function automatic logic [SINE_W-1:0] quarter_sine(input logic [LUT_IDX_W-1:0] idx);
    logic [SINE_W-1:0] s;
    case (idx)
      6'd0:  s = 9'd0;
      6'd1:  s = 9'd13;
      6'd2:  s = 9'd25;
      6'd3:  s = 9'd38;
      6'd4:  s = 9'd50;
      6'd5:  s = 9'd62;
      6'd6:  s = 9'd74;
      6'd7:  s = 9'd86;
      6'd8:  s = 9'd98;
      6'd9:  s = 9'd109;
      6'd10: s = 9'd121;
      6'd11: s = 9'd132;
      6'd12: s = 9'd142;
      6'd13: s = 9'd152;
      6'd14: s = 9'd162;
      6'd15: s = 9'd172;
      6'd16: s = 9'd181;
      6'd17: s = 9'd190;
      6'd18: s = 9'd198;
      6'd19: s = 9'd206;
      6'd20: s = 9'd213;
      6'd21: s = 9'd220;
      6'd22: s = 9'd226;
      6'd23: s = 9'd231;
      6'd24: s = 9'd237;
      6'd25: s = 9'd241;
      6'd26: s = 9'd245;
      6'd27: s = 9'd248;
      6'd28: s = 9'd251;
      6'd29: s = 9'd253;
      6'd30: s = 9'd255;
      6'd31: s = 9'd256;
      6'd32: s = 9'd256;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/rgb_fade_with_breathing.sv
// top level of the three-channel led fader with breathing modulation
//
// usage
// - input channel (in_valid_i / in_stall_o): req_type_i = 1 loads three new
//   targets and sets per-tick steps, req_type_i = 0 is one time tick
// - output channel (out_valid_o / out_stall_i): one item per input item with
//   three duties and the wants_targets flag
// - config channel (cfg_valid_i / cfg_ready_o): index 0 breath depth, index 1
//   timeout in ticks; always ready, write only while the block is idle
// - one item at a time: the breathing index comes from a bit-serial divider,
//   then each channel runs a bit-serial multiply and, on a load, the same
//   divider for its step
// - reset restores the register defaults and clears levels, steps, tick
//   count and phase; no clearing pass is needed
// - a stalled result holds in the output register; the next item may be
//   accepted meanwhile and waits at its last step until the register frees
`default_nettype none

`include "rgb_fade_with_breathing_macros.svh"

module rgb_fade_with_breathing import rfb_pkg::*; #(
  parameter int RAMP_TICKS    = 1000,
  parameter int BREATH_PERIOD = 100,
  parameter int DUTY_MAX      = 1023
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  // input items
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire                   req_type_i,
  input  wire  [TGT_W-1:0]      target_red_i,
  input  wire  [TGT_W-1:0]      target_green_i,
  input  wire  [TGT_W-1:0]      target_blue_i,
  // result items
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output logic [DUTY_W-1:0]     duty_red_o,
  output logic [DUTY_W-1:0]     duty_green_o,
  output logic [DUTY_W-1:0]     duty_blue_o,
  output logic                  wants_targets_o,
  // configuration writes
  input  wire                   cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire  [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire  [CFG_DATA_W-1:0] cfg_data_i
);

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for an item
  localparam logic [2:0] ST_SINE = 3'd1;  // phase * 64 / period on the divider
  localparam logic [2:0] ST_DS   = 3'd2;  // sine lookup, times depth
  localparam logic [2:0] ST_PREP = 3'd3;  // per channel: level update, clamp
  localparam logic [2:0] ST_MUL  = 3'd4;  // clamp * depth * sine, bit-serial
  localparam logic [2:0] ST_DIV  = 3'd5;  // load only: step = diff / ramp
  localparam logic [2:0] ST_FIN  = 3'd6;  // per channel: duty and step
  localparam logic [2:0] ST_OUT  = 3'd7;  // hand over result, tick bookkeeping

  localparam logic [REM_W-1:0]   RAMP_D   = REM_W'(RAMP_TICKS);
  localparam logic [REM_W-1:0]   BREATH_D = REM_W'(BREATH_PERIOD);
  localparam logic [PHASE_W-1:0] BREATH_P = PHASE_W'(BREATH_PERIOD);
  localparam logic [32:0]        DUTY_LIM = 33'(DUTY_MAX) << FRAC_W;

  // control and architectural state
  logic [2:0]          state_q, state_d;
  logic [CH_W-1:0]     ch_q;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  fx_t                 level_q [NUM_CH];
  fx_t                 step_q  [NUM_CH];
  logic [TGT_W-1:0]    first_target_q;
  logic [TICK_W-1:0]   ticks_q;
  logic [PHASE_W-1:0]  phase_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [TICK_W-1:0]   timeout_q;
  logic                out_valid_q;

  // per-item working registers
  logic                is_load_q;
  logic [TGT_W-1:0]    tgt_q   [NUM_CH];
  logic [DS_W-1:0]     ds_q;
  logic [DS_W-1:0]     dssh_q;
  logic [C_W-1:0]      c_q;
  logic [ACC_W-1:0]    acc_q;
  logic [FX_W-1:0]     dvd_q;
  logic [REM_W-1:0]    rem_q;
  logic                neg_q;
  logic [DUTY_W-1:0]   duty_q  [NUM_CH];

  // output register
  logic [DUTY_W-1:0]   duty_red_q, duty_green_q, duty_blue_q;
  logic                wants_q;

  logic in_accept;
  logic out_free;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // shared restoring divider, one quotient bit per cycle; the quotient
  // shifts into the dividend register from the right
  logic [REM_W-1:0] divisor;
  logic [REM_W:0]   rem_sh;
  logic             q_bit;
  logic [REM_W-1:0] rem_nx;

  assign divisor = (state_q == ST_SINE) ? BREATH_D : RAMP_D;
  assign rem_sh  = {rem_q, dvd_q[FX_W-1]};
  assign q_bit   = (rem_sh >= {1'b0, divisor});
  assign rem_nx  = q_bit ? REM_W'(rem_sh - {1'b0, divisor}) : rem_sh[REM_W-1:0];

  // table index from the quotient, mirrored for the falling half
  logic                 j_big;
  logic [6:0]           j_clamp;
  logic [6:0]           j_fold;
  logic [SINE_W-1:0]    sine_val;
  logic [DS_W-1:0]      ds_nx;

  assign j_big    = (dvd_q[FX_W-1:7] != '0) || (dvd_q[6:0] > 7'd64);
  assign j_clamp  = j_big ? 7'd64 : dvd_q[6:0];
  assign j_fold   = (j_clamp > 7'd32) ? (7'd64 - j_clamp) : j_clamp;
  assign sine_val = quarter_sine(j_fold[LUT_IDX_W-1:0]);
  assign ds_nx    = {{(DS_W-DEPTH_W){1'b0}}, depth_q} * {{(DS_W-SINE_W){1'b0}}, sine_val};

  // per-channel level update, clamp and step dividend
  fx_t              lvl_cur, stp_cur, lvl_sum, lvl_use;
  logic [FX_W:0]    sum_w;
  logic [C_W-1:0]   c_nx;
  logic [FX_W:0]    diff;
  logic [FX_W:0]    diff_mag;

  assign lvl_cur = level_q[ch_q];
  assign stp_cur = step_q[ch_q];
  assign sum_w   = {lvl_cur[FX_W-1], lvl_cur} + {stp_cur[FX_W-1], stp_cur};
  // saturate when the sum leaves the signed 29-bit range
  assign lvl_sum = (sum_w[FX_W] != sum_w[FX_W-1]) ? (sum_w[FX_W] ? FX_MIN : FX_MAX)
                                                  : fx_t'(sum_w[FX_W-1:0]);
  assign lvl_use = is_load_q ? lvl_cur : lvl_sum;
  assign c_nx    = lvl_use[FX_W-1] ? '0 :
                   (({5'b0, lvl_use[C_W-1:0]} > DUTY_LIM) ? DUTY_LIM[C_W-1:0]
                                                          : lvl_use[C_W-1:0]);
  assign diff     = {{(FX_W+1-TGT_W-FRAC_W){1'b0}}, tgt_q[ch_q], {FRAC_W{1'b0}}}
                    - {lvl_cur[FX_W-1], lvl_cur};
  assign diff_mag = diff[FX_W] ? (~diff + 1'b1) : diff;

  // serial multiply, msb of depth * sine first
  logic [ACC_W-1:0] acc_nx;
  assign acc_nx = {acc_q[ACC_W-2:0], 1'b0}
                + (dssh_q[DS_W-1] ? {{DS_W{1'b0}}, c_q} : '0);

  // duty and step at the end of a channel
  logic [C_W-1:0]          cut;
  logic [C_W-1:0]          rest;
  logic [C_W-FRAC_W-1:0]   duty_wide;
  logic [DUTY_W-1:0]       duty_nx;
  fx_t                     step_nx;

  assign cut       = acc_q[ACC_W-1:FRAC_W];
  assign rest      = c_q - cut;
  assign duty_wide = rest[C_W-1:FRAC_W];
  assign duty_nx   = (duty_wide > (C_W-FRAC_W)'(DUTY_SAT)) ? DUTY_SAT
                                                          : duty_wide[DUTY_W-1:0];
  // truncation toward zero on the magnitude, then sign and saturate
  assign step_nx   = neg_q ? (dvd_q[FX_W-1] ? FX_MIN : fx_t'(~dvd_q + 1'b1))
                           : (dvd_q[FX_W-1] ? FX_MAX : fx_t'(dvd_q));

  // tick bookkeeping and request flag
  logic [TICK_W-1:0]       ticks_new;
  logic signed [FX_W:0]    lv0_w, tgt0_w;
  logic                    arrived;
  logic                    flag_nx;
  logic [PHASE_W-1:0]      phase_inc, phase_nx;

  assign ticks_new = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
  assign lv0_w     = {level_q[0][FX_W-1], level_q[0]};
  assign tgt0_w    = {{(FX_W+1-TGT_W-FRAC_W){1'b0}}, first_target_q, {FRAC_W{1'b0}}};
  assign arrived   = (step_q[0] == '0)
                   || (!step_q[0][FX_W-1] && (lv0_w >= tgt0_w))
                   || ( step_q[0][FX_W-1] && (lv0_w <= tgt0_w));
  assign flag_nx   = arrived || (ticks_new > timeout_q);
  assign phase_inc = phase_q + 1'b1;
  assign phase_nx  = (phase_inc > BREATH_P) ? '0 : phase_inc;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) state_d = ST_SINE;
      end
      ST_SINE: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_DS;
      end
      ST_DS:   state_d = ST_PREP;
      ST_PREP: state_d = ST_MUL;
      ST_MUL: begin
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) state_d = is_load_q ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_FIN;
      end
      ST_FIN: begin
        state_d = (ch_q == CH_W'(NUM_CH - 1)) ? ST_OUT : ST_PREP;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // bit counter restarts on every state change
  assign cnt_d = (state_d != state_q) ? '0 : cnt_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      ch_q           <= '0;
      cnt_q          <= '0;
      for (int i = 0; i < NUM_CH; i++) begin
        level_q[i] <= '0;
        step_q[i]  <= '0;
      end
      first_target_q <= '0;
      ticks_q        <= '0;
      phase_q        <= '0;
      depth_q        <= DEPTH_RST;
      timeout_q      <= TIMEOUT_RST;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;

      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_BREATH_DEPTH:  depth_q   <= cfg_data_i[DEPTH_W-1:0];
          REG_TIMEOUT_TICKS: timeout_q <= cfg_data_i[TICK_W-1:0];
          default: ;
        endcase
      end

      if (in_accept) ch_q <= '0;
      if (state_q == ST_FIN && ch_q != CH_W'(NUM_CH - 1)) ch_q <= ch_q + 1'b1;

      // a tick moves the stored level, unclamped
      if (state_q == ST_PREP && !is_load_q) level_q[ch_q] <= lvl_sum;
      if (state_q == ST_FIN && is_load_q)   step_q[ch_q]  <= step_nx;

      if (state_q == ST_OUT && out_free) begin
        if (is_load_q) begin
          first_target_q <= tgt_q[0];
          ticks_q        <= '0;
        end else begin
          ticks_q <= ticks_new;
          phase_q <= phase_nx;
        end
      end

      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i)             out_valid_q <= 1'b0;
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          is_load_q <= req_type_i;
          tgt_q[0]  <= target_red_i;
          tgt_q[1]  <= target_green_i;
          tgt_q[2]  <= target_blue_i;
          dvd_q     <= {{(FX_W-PHASE_W-6){1'b0}}, phase_q, 6'b0};
          rem_q     <= '0;
        end
      end
      ST_SINE, ST_DIV: begin
        dvd_q <= {dvd_q[FX_W-2:0], q_bit};
        rem_q <= rem_nx;
      end
      ST_DS: ds_q <= ds_nx;
      ST_PREP: begin
        c_q    <= c_nx;
        acc_q  <= '0;
        dssh_q <= ds_q;
        dvd_q  <= diff_mag[FX_W-1:0];
        neg_q  <= diff[FX_W];
        rem_q  <= '0;
      end
      ST_MUL: begin
        acc_q  <= acc_nx;
        dssh_q <= {dssh_q[DS_W-2:0], 1'b0};
      end
      ST_FIN: duty_q[ch_q] <= duty_nx;
      ST_OUT: begin
        if (out_free) begin
          duty_red_q   <= duty_q[0];
          duty_green_q <= duty_q[1];
          duty_blue_q  <= duty_q[2];
          wants_q      <= is_load_q ? 1'b0 : flag_nx;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o     = out_valid_q;
  assign duty_red_o      = duty_red_q;
  assign duty_green_o    = duty_green_q;
  assign duty_blue_o     = duty_blue_q;
  assign wants_targets_o = wants_q;

  // checks
  `RFB_ASSERT(a_ch_range, ch_q < CH_W'(NUM_CH), "channel index out of range")
  `RFB_ASSERT(a_mul_cnt, (state_q != ST_MUL) || (cnt_q < CNT_W'(MUL_STEPS)), "mul overrun")
  `RFB_ASSERT_NEXT(a_load_flag, (state_q == ST_OUT) && out_free && is_load_q, out_valid_o && !wants_targets_o, "load result raised the flag")
  `RFB_ASSERT_NEXT(a_timeout_flag, (state_q == ST_OUT) && out_free && !is_load_q && (ticks_new > timeout_q), out_valid_o && wants_targets_o, "timeout did not raise the flag")

endmodule

`default_nettype wire
